// ===== rtl/priority_led_action_blinker_top_assert.svh =====
// assertion macros for the priority led action blinker
`ifndef PRIORITY_LED_ACTION_BLINKER_TOP_ASSERT_SVH
`define PRIORITY_LED_ACTION_BLINKER_TOP_ASSERT_SVH

// same-cycle implication, sampled on aclk, off during reset
`define PLAB_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("plab assertion failed");

// next-cycle implication, sampled on aclk, off during reset
`define PLAB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("plab assertion failed");

`endif

// ===== rtl/plab_pkg.sv =====
// shared types and constants for the priority led action blinker
`default_nettype none

package plab_pkg;

    // default sizes
    localparam int NUM_LEDS_DEF   = 8;
    localparam int NUM_LAYERS_DEF = 4;

    // port field widths
    localparam int PIN_W   = 8;
    localparam int CODE_W  = 3;
    localparam int TIMES_W = 2;
    localparam int DUR_W   = 2;
    localparam int PRIO_W  = 2;
    localparam int ENTRY_W = CODE_W + TIMES_W + DUR_W;
    localparam int CNT_W   = 8;

    // action codes, codes five to seven act as hold
    localparam logic [CODE_W-1:0] CODE_NONE  = 3'd0;
    localparam logic [CODE_W-1:0] CODE_OFF   = 3'd1;
    localparam logic [CODE_W-1:0] CODE_ON    = 3'd2;
    localparam logic [CODE_W-1:0] CODE_REV   = 3'd3;
    localparam logic [CODE_W-1:0] CODE_BLINK = 3'd4;

    // blink counter fields
    localparam logic [CNT_W-1:0] CNT_TIMES_MASK = 8'h03;
    localparam logic [CNT_W-1:0] CNT_LO_MASK    = 8'h0F;
    localparam logic [CNT_W-1:0] CNT_HI_MASK    = 8'hF0;
    localparam logic [CNT_W-1:0] CNT_ONE_BLINK  = 8'h10;

    typedef enum logic [1:0] {
        OP_APPLY      = 2'd0,
        OP_TICK       = 2'd1,
        OP_SAVE_ENTER = 2'd2,
        OP_SAVE_EXIT  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_APPLY,
        ST_APPLY_REF,
        ST_TICK,
        ST_TICK_REF,
        ST_FINISH
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic apply_write;
        logic refresh;
        logic tick_step;
        logic idx_inc;
        logic load_result;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        op_t  op;
        logic apply_hit;
        logic expire;
        logic last;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/plab_datapath.sv =====
// led action layers, blink counters, led and pin state, result register
`default_nettype none

module plab_datapath #(
    parameter int NUM_LEDS   = plab_pkg::NUM_LEDS_DEF,
    parameter int NUM_LAYERS = plab_pkg::NUM_LAYERS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_we,
    input  wire logic [plab_pkg::PIN_W-1:0]   cfg_data,
    input  wire logic [1:0]                   in_opcode,
    input  wire logic [plab_pkg::PIN_W-1:0]   in_led_select,
    input  wire logic [plab_pkg::CODE_W-1:0]  in_action_code,
    input  wire logic [plab_pkg::TIMES_W-1:0] in_blink_times,
    input  wire logic [plab_pkg::DUR_W-1:0]   in_blink_duration,
    input  wire logic [plab_pkg::PRIO_W-1:0]  in_priority_req,
    input  wire plab_pkg::dp_cmd_t            cmd,
    output plab_pkg::dp_stat_t                stat,
    output logic [plab_pkg::PIN_W-1:0]        res_pin_levels,
    output logic [plab_pkg::PIN_W-1:0]        res_led_states,
    output logic                              res_pins_written,
    output logic                              res_wake_request
);
    import plab_pkg::*;

    localparam int LED_W   = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
    localparam int LAYER_W = (NUM_LAYERS > 1) ? $clog2(NUM_LAYERS) : 1;

    // storage
    logic [ENTRY_W-1:0]  layers_reg   [NUM_LEDS][NUM_LAYERS];
    logic [ENTRY_W-1:0]  layers_next  [NUM_LEDS][NUM_LAYERS];
    logic [CNT_W-1:0]    counters_reg [NUM_LEDS];
    logic [CNT_W-1:0]    counters_next[NUM_LEDS];
    logic [NUM_LEDS-1:0] led_reg, led_next;
    logic [NUM_LEDS-1:0] driven_reg, driven_next;
    logic                saving_reg, saving_next;
    logic [NUM_LEDS-1:0] cfg_mask_reg;
    logic [LED_W-1:0]    idx_reg, idx_next;
    logic                change_reg, change_next;

    // captured item
    op_t                 op_reg;
    logic [NUM_LEDS-1:0] mask_reg;
    logic [CODE_W-1:0]   code_reg;
    logic [TIMES_W-1:0]  times_reg;
    logic [DUR_W-1:0]    dur_reg;
    logic [PRIO_W-1:0]   prio_reg;

    // result register
    logic [NUM_LEDS-1:0] res_pins_reg, res_leds_reg;
    logic                res_written_reg, res_wake_reg;
    logic                written_next, wake_next;

    // per led top layer and its code
    logic [LAYER_W-1:0]  top_idx [NUM_LEDS];
    logic [CODE_W-1:0]   top_code[NUM_LEDS];

    // tick step terms for the current led
    logic [ENTRY_W-1:0]  t_entry;
    logic [TIMES_W-1:0]  t_times;
    logic [DUR_W-1:0]    t_dur;
    logic [CNT_W-1:0]    t_cnt;
    logic [CNT_W-1:0]    t_reload;
    logic [CNT_W-1:0]    t_cnt_new;
    logic                t_blink;
    logic                t_expire;
    logic                t_phase_end;
    logic                apply_hit;
    logic [ENTRY_W-1:0]  new_entry;

    function automatic logic [NUM_LEDS-1:0] pins_for(input logic [NUM_LEDS-1:0] v,
                                                     input logic [NUM_LEDS-1:0] pol);
        return ~(v ^ pol);
    endfunction

    // highest layer holding an action
    always_comb begin
        for (int j = 0; j < NUM_LEDS; j++) begin
            top_idx[j] = '0;
            for (int k = 0; k < NUM_LAYERS; k++) begin
                if (layers_reg[j][k][CODE_W-1:0] != CODE_NONE) begin
                    top_idx[j] = LAYER_W'(k);
                end
            end
            top_code[j] = layers_reg[j][top_idx[j]][CODE_W-1:0];
        end
    end

    // blink step for the led under the walk index
    always_comb begin
        t_entry     = layers_reg[idx_reg][top_idx[idx_reg]];
        t_times     = t_entry[CODE_W +: TIMES_W];
        t_dur       = t_entry[CODE_W+TIMES_W +: DUR_W];
        t_cnt       = counters_reg[idx_reg];
        t_blink     = (t_entry[CODE_W-1:0] == CODE_BLINK);
        t_expire    = t_blink && (t_times != '0)
                      && ((t_cnt >> 4) >= (CNT_W'(t_times) & CNT_TIMES_MASK));
        t_phase_end = ((t_cnt & CNT_LO_MASK) == '0);
        t_reload    = (t_cnt & CNT_HI_MASK) + CNT_W'(t_dur);
        if ((t_times != '0) && led_reg[idx_reg]) begin
            t_reload = t_reload + CNT_ONE_BLINK;
        end
        t_cnt_new   = (t_phase_end ? t_reload : t_cnt) - CNT_W'(1);
    end

    assign apply_hit = (int'(prio_reg) < NUM_LAYERS) && (mask_reg != '0);
    assign new_entry = {dur_reg, times_reg, code_reg};

    // next state of layers, counters, leds and walk
    always_comb begin
        layers_next   = layers_reg;
        counters_next = counters_reg;
        led_next      = led_reg;
        idx_next      = idx_reg;
        change_next   = change_reg;

        if (cmd.capture) begin
            idx_next    = '0;
            change_next = 1'b0;
        end

        // write the entry into one layer of every selected led
        if (cmd.apply_write && apply_hit) begin
            for (int j = 0; j < NUM_LEDS; j++) begin
                if (mask_reg[j]) begin
                    counters_next[j] = '0;
                    for (int k = 0; k < NUM_LAYERS; k++) begin
                        if (int'(prio_reg) == k) begin
                            layers_next[j][k] = new_entry;
                        end
                    end
                end
            end
        end

        // refresh every led from its top action
        if (cmd.refresh) begin
            for (int j = 0; j < NUM_LEDS; j++) begin
                case (top_code[j])
                    CODE_NONE, CODE_OFF: led_next[j] = 1'b0;
                    CODE_ON:             led_next[j] = 1'b1;
                    CODE_REV:            led_next[j] = ~led_reg[j];
                    default:             led_next[j] = led_reg[j];
                endcase
            end
        end

        // one blink step
        if (cmd.tick_step && t_blink) begin
            if (t_expire) begin
                layers_next[idx_reg][top_idx[idx_reg]] = '0;
                counters_next[idx_reg] = '0;
                change_next = 1'b1;
            end else begin
                counters_next[idx_reg] = t_cnt_new;
                if (t_phase_end) begin
                    led_next[idx_reg] = ~led_reg[idx_reg];
                    change_next = 1'b1;
                end
            end
        end

        if (cmd.idx_inc) begin
            idx_next = idx_reg + LED_W'(1);
        end
    end

    // pins, power save and result flags at the end of an item
    always_comb begin
        driven_next  = driven_reg;
        saving_next  = saving_reg;
        written_next = 1'b0;
        wake_next    = 1'b0;
        case (op_reg)
            OP_APPLY: begin
                if (apply_hit) begin
                    driven_next  = pins_for(led_reg, cfg_mask_reg);
                    written_next = 1'b1;
                    wake_next    = 1'b1;
                end
            end
            OP_TICK: begin
                if (change_reg && !saving_reg) begin
                    driven_next  = pins_for(led_reg, cfg_mask_reg);
                    written_next = 1'b1;
                end
            end
            OP_SAVE_ENTER: begin
                driven_next  = pins_for('0, cfg_mask_reg);
                saving_next  = 1'b1;
                written_next = 1'b1;
            end
            OP_SAVE_EXIT: begin
                driven_next  = pins_for(led_reg, cfg_mask_reg);
                saving_next  = 1'b0;
                written_next = 1'b1;
            end
            default: begin
                written_next = 1'b0;
            end
        endcase
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < NUM_LEDS; j++) begin
                counters_reg[j] <= '0;
                for (int k = 0; k < NUM_LAYERS; k++) begin
                    layers_reg[j][k] <= '0;
                end
            end
            led_reg      <= '0;
            driven_reg   <= '0;
            saving_reg   <= 1'b0;
            cfg_mask_reg <= '1;
            idx_reg      <= '0;
            change_reg   <= 1'b0;
        end else begin
            layers_reg   <= layers_next;
            counters_reg <= counters_next;
            led_reg      <= led_next;
            idx_reg      <= idx_next;
            change_reg   <= change_next;
            if (cmd.load_result) begin
                driven_reg <= driven_next;
                saving_reg <= saving_next;
            end
            if (cfg_we) begin
                cfg_mask_reg <= cfg_data[NUM_LEDS-1:0];
            end
        end
    end

    // item capture
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg    <= op_t'(in_opcode);
            mask_reg  <= in_led_select[NUM_LEDS-1:0];
            code_reg  <= in_action_code;
            times_reg <= in_blink_times;
            dur_reg   <= in_blink_duration;
            prio_reg  <= in_priority_req;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.load_result) begin
            res_pins_reg    <= driven_next;
            res_leds_reg    <= led_reg;
            res_written_reg <= written_next;
            res_wake_reg    <= wake_next;
        end
    end

    assign stat.op        = op_reg;
    assign stat.apply_hit = apply_hit;
    assign stat.expire    = t_expire;
    assign stat.last      = (idx_reg == LED_W'(NUM_LEDS - 1));

    assign res_pin_levels   = PIN_W'(res_pins_reg);
    assign res_led_states   = PIN_W'(res_leds_reg);
    assign res_pins_written = res_written_reg;
    assign res_wake_request = res_wake_reg;

endmodule

`default_nettype wire

// ===== rtl/plab_ctrl.sv =====
// controller: item sequencing, led walk control and result handshake
`default_nettype none

module plab_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output plab_pkg::dp_cmd_t       cmd,
    input  wire plab_pkg::dp_stat_t stat
);
    import plab_pkg::*;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    // state and output valid registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        s_ready      = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
                if (s_valid) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                case (stat.op)
                    OP_APPLY: state_next = ST_APPLY;
                    OP_TICK:  state_next = ST_TICK;
                    default:  state_next = ST_FINISH;
                endcase
            end
            ST_APPLY: begin
                cmd.apply_write = 1'b1;
                state_next = stat.apply_hit ? ST_APPLY_REF : ST_FINISH;
            end
            ST_APPLY_REF: begin
                cmd.refresh = 1'b1;
                state_next  = ST_FINISH;
            end
            ST_TICK: begin
                cmd.tick_step = 1'b1;
                if (stat.expire) begin
                    state_next = ST_TICK_REF;
                end else if (stat.last) begin
                    state_next = ST_FINISH;
                end else begin
                    cmd.idx_inc = 1'b1;
                end
            end
            ST_TICK_REF: begin
                // expired blink: re-evaluate every led, then go on walking
                cmd.refresh = 1'b1;
                if (stat.last) begin
                    state_next = ST_FINISH;
                end else begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_TICK;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.load_result = 1'b1;
                    m_valid_next    = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

// ===== rtl/priority_led_action_blinker_top.sv =====
// top level of the priority led action blinker
//
//  channel  direction  handshake              payload
//  s_       in         s_valid / s_ready      opcode, led select, action fields, priority
//  m_       out        m_valid / m_ready      pin levels, led states, written, wake
//  cfg_     in         cfg_valid / cfg_ready  cfg_data (active_high_mask)
//
// power save items go from decode to finish; apply items pass an apply step and,
// on a hit, a refresh; ticks walk every led, plus one refresh per expiring blink.
// one item is in work at a time; the result register holds a finished result
// while the next item is taken.
// synchronous active-low reset clears all layers, counters and led state.
// a stalled m_ready holds the finished item in its last step; cfg_ready is always high.
`default_nettype none

module priority_led_action_blinker_top #(
    parameter int NUM_LEDS   = plab_pkg::NUM_LEDS_DEF,
    parameter int NUM_LAYERS = plab_pkg::NUM_LAYERS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [plab_pkg::PIN_W-1:0]   cfg_data,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [1:0]                   s_opcode,
    input  wire logic [plab_pkg::PIN_W-1:0]   s_led_select,
    input  wire logic [plab_pkg::CODE_W-1:0]  s_action_code,
    input  wire logic [plab_pkg::TIMES_W-1:0] s_blink_times,
    input  wire logic [plab_pkg::DUR_W-1:0]   s_blink_duration,
    input  wire logic [plab_pkg::PRIO_W-1:0]  s_priority_req,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [plab_pkg::PIN_W-1:0]        m_pin_levels,
    output logic [plab_pkg::PIN_W-1:0]        m_led_states,
    output logic                              m_pins_written,
    output logic                              m_wake_request
);
    import plab_pkg::*;

`include "priority_led_action_blinker_top_assert.svh"

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    plab_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    plab_datapath #(
        .NUM_LEDS   (NUM_LEDS),
        .NUM_LAYERS (NUM_LAYERS)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_valid && cfg_ready),
        .cfg_data          (cfg_data),
        .in_opcode         (s_opcode),
        .in_led_select     (s_led_select),
        .in_action_code    (s_action_code),
        .in_blink_times    (s_blink_times),
        .in_blink_duration (s_blink_duration),
        .in_priority_req   (s_priority_req),
        .cmd               (cmd),
        .stat              (stat),
        .res_pin_levels    (m_pin_levels),
        .res_led_states    (m_led_states),
        .res_pins_written  (m_pins_written),
        .res_wake_request  (m_wake_request)
    );

    // one item at a time: no second input transfer right after one
    `PLAB_ASSERT_NEXT(a_one_item_in_work, s_valid && s_ready, !s_ready)
    // a wake request only comes with a pin update
    `PLAB_ASSERT_IMPL(a_wake_with_pins, m_valid, !m_wake_request || m_pins_written)
    // nothing reported above the last led
    `PLAB_ASSERT_IMPL(a_unused_bits_zero, m_valid,
                      ((m_pin_levels >> NUM_LEDS) == '0) && ((m_led_states >> NUM_LEDS) == '0))

endmodule

`default_nettype wire

// ===== verif/led_result_checker.sv =====
// result checker for the priority led action blinker: tracks transfers, predicts, compares
`timescale 1ns / 100ps

module led_result_checker
    import plab_pkg::*;
#(
    parameter int NUM_LEDS   = NUM_LEDS_DEF,
    parameter int NUM_LAYERS = NUM_LAYERS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [PIN_W-1:0]   cfg_data,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [1:0]         s_opcode,
    input  logic [PIN_W-1:0]   s_led_select,
    input  logic [CODE_W-1:0]  s_action_code,
    input  logic [TIMES_W-1:0] s_blink_times,
    input  logic [DUR_W-1:0]   s_blink_duration,
    input  logic [PRIO_W-1:0]  s_priority_req,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [PIN_W-1:0]   m_pin_levels,
    input  logic [PIN_W-1:0]   m_led_states,
    input  logic               m_pins_written,
    input  logic               m_wake_request,
    output int                 fail_count,
    output int                 pending,
    output int                 checked
);

    localparam logic [PIN_W-1:0] LED_ALL = PIN_W'((1 << NUM_LEDS) - 1);

    typedef struct packed {
        logic [PIN_W-1:0] pins;
        logic [PIN_W-1:0] states;
        logic             written;
        logic             wake;
    } led_result_t;

    // shadow copy of the block state
    logic [ENTRY_W-1:0] layer_entry [NUM_LAYERS][NUM_LEDS];
    logic [CNT_W-1:0]   blink_cnt [NUM_LEDS];
    logic [PIN_W-1:0]   lit;
    logic [PIN_W-1:0]   pin_drive;
    logic               save_mode;
    logic [PIN_W-1:0]   polarity;

    led_result_t expected_leds [$];

    function automatic logic [PIN_W-1:0] pin_image(input logic [PIN_W-1:0] v);
        return ~(v ^ polarity) & LED_ALL;
    endfunction

    // highest layer holding an action, layer 0 when none does
    function automatic int top_of(input int led);
        for (int j = NUM_LAYERS - 1; j >= 0; j--) begin
            if (layer_entry[j][led][CODE_W-1:0] != CODE_NONE)
                return j;
        end
        return 0;
    endfunction

    function automatic void refresh_leds();
        logic [CODE_W-1:0] c;
        for (int i = 0; i < NUM_LEDS; i++) begin
            c = layer_entry[top_of(i)][i][CODE_W-1:0];
            if (c == CODE_NONE || c == CODE_OFF)
                lit[i] = 1'b0;
            else if (c == CODE_ON)
                lit[i] = 1'b1;
            else if (c == CODE_REV)
                lit[i] = ~lit[i];
        end
    endfunction

    function automatic void clear_model();
        for (int j = 0; j < NUM_LAYERS; j++)
            for (int i = 0; i < NUM_LEDS; i++)
                layer_entry[j][i] = '0;
        for (int i = 0; i < NUM_LEDS; i++)
            blink_cnt[i] = '0;
        lit        = '0;
        save_mode  = 1'b0;
        polarity   = 8'hFF;
        pin_drive  = pin_image('0);
    endfunction

    // advances the shadow state by one item and returns its result
    function automatic led_result_t predict_led_item(
        input logic [1:0]         op,
        input logic [PIN_W-1:0]   mask,
        input logic [CODE_W-1:0]  code,
        input logic [TIMES_W-1:0] times,
        input logic [DUR_W-1:0]   dur,
        input logic [PRIO_W-1:0]  prio
    );
        led_result_t        res;
        logic               hit;
        logic [ENTRY_W-1:0] e;
        logic [TIMES_W-1:0] t;
        logic [CNT_W-1:0]   cnt;
        int                 j;
        res = '0;
        hit = 1'b0;
        case (op)
            OP_APPLY: begin
                if (prio < NUM_LAYERS) begin
                    for (int i = 0; i < NUM_LEDS; i++) begin
                        if (mask[i]) begin
                            layer_entry[prio][i] = {dur, times, code};
                            blink_cnt[i] = '0;
                            hit = 1'b1;
                        end
                    end
                end
                if (hit) begin
                    refresh_leds();
                    pin_drive   = pin_image(lit);
                    res.written = 1'b1;
                    res.wake    = 1'b1;
                end
            end
            OP_TICK: begin
                // walk the leds in order, only blinking ones move
                for (int i = 0; i < NUM_LEDS; i++) begin
                    j = top_of(i);
                    e = layer_entry[j][i];
                    if (e[CODE_W-1:0] != CODE_BLINK)
                        continue;
                    t   = e[CODE_W +: TIMES_W];
                    cnt = blink_cnt[i];
                    // blink count reached, drop the entry
                    if (t != 0 && (cnt >> 4) >= t) begin
                        layer_entry[j][i] = '0;
                        blink_cnt[i] = '0;
                        refresh_leds();
                        hit = 1'b1;
                        continue;
                    end
                    // phase over, reload and toggle
                    if ((cnt & CNT_LO_MASK) == 0) begin
                        cnt = (cnt & CNT_HI_MASK) + CNT_W'(e[CODE_W+TIMES_W +: DUR_W]);
                        if (t != 0 && lit[i])
                            cnt = cnt + CNT_ONE_BLINK;
                        lit[i] = ~lit[i];
                        hit = 1'b1;
                    end
                    blink_cnt[i] = cnt - 8'd1;
                end
                if (hit && !save_mode) begin
                    pin_drive   = pin_image(lit);
                    res.written = 1'b1;
                end
            end
            OP_SAVE_ENTER: begin
                pin_drive   = pin_image('0);
                save_mode   = 1'b1;
                res.written = 1'b1;
            end
            default: begin
                pin_drive   = pin_image(lit);
                save_mode   = 1'b0;
                res.written = 1'b1;
            end
        endcase
        res.pins   = pin_drive & LED_ALL;
        res.states = lit & LED_ALL;
        return res;
    endfunction

    always @(posedge aclk) begin : watch
        led_result_t got;
        led_result_t want;
        if (!aresetn) begin
            clear_model();
            expected_leds.delete();
        end else begin
            // result transfer against the oldest expectation
            if (m_valid && m_ready) begin
                got = '{m_pin_levels, m_led_states, m_pins_written, m_wake_request};
                if (expected_leds.size() == 0) begin
                    $display("%0t: unexpected result pins %h states %h written %b wake %b",
                             $time, got.pins, got.states, got.written, got.wake);
                    fail_count++;
                end else begin
                    want = expected_leds.pop_front();
                    checked++;
                    if (got.pins !== want.pins) begin
                        $display("%0t: pin_levels expected %h actual %h",
                                 $time, want.pins, got.pins);
                        fail_count++;
                    end
                    if (got.states !== want.states) begin
                        $display("%0t: led_states expected %h actual %h",
                                 $time, want.states, got.states);
                        fail_count++;
                    end
                    if (got.written !== want.written) begin
                        $display("%0t: pins_written expected %b actual %b",
                                 $time, want.written, got.written);
                        fail_count++;
                    end
                    if (got.wake !== want.wake) begin
                        $display("%0t: wake_request expected %b actual %b",
                                 $time, want.wake, got.wake);
                        fail_count++;
                    end
                end
            end
            // polarity write
            if (cfg_valid && cfg_ready)
                polarity = cfg_data;
            // input transfer
            if (s_valid && s_ready)
                expected_leds.push_back(predict_led_item(s_opcode, s_led_select, s_action_code,
                                                         s_blink_times, s_blink_duration,
                                                         s_priority_req));
        end
        pending <= expected_leds.size();
    end

endmodule

// ===== verif/testbench.sv =====
// testbench top: stimulus, handshake pacing and verdict for the led action blinker
`timescale 1ns / 100ps

module testbench;
    import plab_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 300;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic               cfg_valid        = 1'b0;
    logic               cfg_ready;
    logic [PIN_W-1:0]   cfg_data         = '0;
    logic               s_valid          = 1'b0;
    logic               s_ready;
    logic [1:0]         s_opcode         = OP_APPLY;
    logic [PIN_W-1:0]   s_led_select     = '0;
    logic [CODE_W-1:0]  s_action_code    = CODE_NONE;
    logic [TIMES_W-1:0] s_blink_times    = '0;
    logic [DUR_W-1:0]   s_blink_duration = '0;
    logic [PRIO_W-1:0]  s_priority_req   = '0;
    logic               m_valid;
    logic               m_ready          = 1'b0;
    logic [PIN_W-1:0]   m_pin_levels;
    logic [PIN_W-1:0]   m_led_states;
    logic               m_pins_written;
    logic               m_wake_request;

    int fail_count;
    int pending;
    int checked;

    // handshake pacing, percent of cycles
    int idle_pct  = 0;
    int stall_pct = 0;

    int n_apply = 0;
    int n_tick  = 0;
    int n_save  = 0;
    int n_cfg   = 0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    priority_led_action_blinker_top dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_opcode         (s_opcode),
        .s_led_select     (s_led_select),
        .s_action_code    (s_action_code),
        .s_blink_times    (s_blink_times),
        .s_blink_duration (s_blink_duration),
        .s_priority_req   (s_priority_req),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_pin_levels     (m_pin_levels),
        .m_led_states     (m_led_states),
        .m_pins_written   (m_pins_written),
        .m_wake_request   (m_wake_request)
    );

    led_result_checker scoreboard (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_opcode         (s_opcode),
        .s_led_select     (s_led_select),
        .s_action_code    (s_action_code),
        .s_blink_times    (s_blink_times),
        .s_blink_duration (s_blink_duration),
        .s_priority_req   (s_priority_req),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_pin_levels     (m_pin_levels),
        .m_led_states     (m_led_states),
        .m_pins_written   (m_pins_written),
        .m_wake_request   (m_wake_request),
        .fail_count       (fail_count),
        .pending          (pending),
        .checked          (checked)
    );

    // receiver stalls
    always @(posedge aclk)
        m_ready <= ($urandom_range(99) >= stall_pct);

    // one input transfer, with an optional idle gap ahead of it
    task automatic send_item(input op_t op, input logic [PIN_W-1:0] mask,
                             input logic [CODE_W-1:0] code, input logic [TIMES_W-1:0] times,
                             input logic [DUR_W-1:0] dur, input logic [PRIO_W-1:0] prio);
        if ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < idle_pct)
                @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_opcode         <= op;
        s_led_select     <= mask;
        s_action_code    <= code;
        s_blink_times    <= times;
        s_blink_duration <= dur;
        s_priority_req   <= prio;
        do @(posedge aclk); while (!s_ready);
        case (op)
            OP_APPLY: n_apply++;
            OP_TICK:  n_tick++;
            default:  n_save++;
        endcase
    endtask

    // tick or power save item, unused fields carry random values
    task automatic send_ctrl(input op_t op);
        send_item(op, PIN_W'($urandom), CODE_W'($urandom), TIMES_W'($urandom),
                  DUR_W'($urandom), PRIO_W'($urandom));
    endtask

    // sender holds off until every expected result has come
    task automatic wait_for_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    task automatic write_polarity(input logic [PIN_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        n_cfg++;
    endtask

    // mostly single leds so blink entries live long enough to expire
    function automatic logic [PIN_W-1:0] pick_mask();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return PIN_W'(1) << $urandom_range(PIN_W - 1);
        else if (r < 95)
            return PIN_W'($urandom);
        else
            return '0;
    endfunction

    // watchdog on cycles without any transfer
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
        $display("simulation failed");
        $finish;
    end

    initial begin : stimulus
        logic [PIN_W-1:0] pol_list [PHASES];
        logic [PIN_W-1:0] pol;
        int sent;
        int r;
        int failures;
        pol_list = '{8'hFF, 8'h00, 8'hA5, 8'h00, 8'h5A, 8'h0F};

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        for (int phase = 0; phase < PHASES; phase++) begin
            // pacing: none, sender idle, receiver stall, both lightly
            case (phase % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 75; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 75; end
                default: begin idle_pct = 7; stall_pct = 7; end
            endcase
            pol = (phase == 3) ? PIN_W'($urandom) : pol_list[phase];
            write_polarity(pol);

            if (phase == 0) begin
                // directed: layering, reverse, holds, blink corners, power save
                send_item(OP_APPLY, 8'hFF, CODE_ON, 2'd0, 2'd0, 2'd0);
                send_ctrl(OP_TICK);
                send_item(OP_APPLY, 8'h0F, CODE_OFF, 2'd1, 2'd2, 2'd1);
                send_item(OP_APPLY, 8'h81, CODE_REV, 2'd0, 2'd0, 2'd3);
                send_item(OP_APPLY, 8'h01, CODE_REV, 2'd3, 2'd3, 2'd3);
                send_item(OP_APPLY, 8'h00, CODE_ON, 2'd3, 2'd3, 2'd3);
                send_item(OP_APPLY, 8'h02, CODE_W'(5), 2'd2, 2'd1, 2'd2);
                send_item(OP_APPLY, 8'h04, CODE_W'(6), 2'd1, 2'd2, 2'd2);
                send_item(OP_APPLY, 8'h08, CODE_W'(7), 2'd3, 2'd3, 2'd2);
                send_item(OP_APPLY, 8'hFF, CODE_NONE, 2'd0, 2'd0, 2'd3);
                send_item(OP_APPLY, 8'h10, CODE_BLINK, 2'd0, 2'd0, 2'd3);
                send_item(OP_APPLY, 8'h20, CODE_BLINK, 2'd3, 2'd3, 2'd2);
                send_item(OP_APPLY, 8'h40, CODE_BLINK, 2'd1, 2'd0, 2'd3);
                repeat (6) send_ctrl(OP_TICK);
                send_ctrl(OP_SAVE_ENTER);
                send_ctrl(OP_TICK);
                send_item(OP_APPLY, 8'h80, CODE_BLINK, 2'd2, 2'd1, 2'd1);
                send_ctrl(OP_SAVE_EXIT);
                send_ctrl(OP_SAVE_ENTER);
                send_ctrl(OP_SAVE_ENTER);
                send_ctrl(OP_SAVE_EXIT);
            end

            // random part: blink bursts followed by tick runs, plus noise
            sent = n_apply + n_tick + n_save;
            while (n_apply + n_tick + n_save - sent < PHASE_ITEMS) begin
                r = $urandom_range(99);
                if (r < 10) begin
                    send_item(OP_APPLY, pick_mask(), CODE_BLINK, TIMES_W'($urandom),
                              DUR_W'($urandom), PRIO_W'($urandom));
                    repeat ($urandom_range(4, 30)) send_ctrl(OP_TICK);
                end else if (r < 50) begin
                    send_ctrl(OP_TICK);
                end else if (r < 85) begin
                    send_item(OP_APPLY, pick_mask(),
                              ($urandom_range(99) < 40) ? CODE_BLINK : CODE_W'($urandom),
                              TIMES_W'($urandom), DUR_W'($urandom), PRIO_W'($urandom));
                end else if (r < 92) begin
                    send_ctrl(OP_SAVE_ENTER);
                end else if (r < 99) begin
                    send_ctrl(OP_SAVE_EXIT);
                end else begin
                    wait_for_results();
                end
            end
            wait_for_results();
        end

        // let any stray result show up before the verdict
        repeat (40) @(posedge aclk);
        failures = fail_count;
        if (pending != 0) begin
            $display("%0t: %0d expected results never arrived", $time, pending);
            failures++;
        end

        $display("covered %0d items: %0d apply, %0d tick, %0d power save; %0d results checked",
                 n_apply + n_tick + n_save, n_apply, n_tick, n_save, checked);
        $display("%0d polarity writes over %0d pacing phases, %0d failures",
                 n_cfg, PHASES, failures);
        if (failures == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
